FILE: sv/isw_pkg.sv
// Shared types and helpers for the integer set with width upgrade.
// Used by the top level and by its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isw_pkg;

  // Element width code
  typedef enum logic [1:0] {
    W16 = 2'd0,
    W32 = 2'd1,
    W64 = 2'd2
  } width_e;

  // Operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam int unsigned ValueW = 64;

  // Operand type; code three counts as 64-bit
  function automatic width_e type_code(input logic [1:0] t);
    width_e w;
    unique case (t)
      2'd0:    w = W16;
      2'd1:    w = W32;
      default: w = W64;
    endcase
    return w;
  endfunction

  // Keep the low 16/32/64 bits and sign-extend them
  function automatic logic [ValueW-1:0] sign_fit(input logic [ValueW-1:0] v,
                                                 input width_e code);
    logic [ValueW-1:0] r;
    unique case (code)
      W16:     r = {{(ValueW-16){v[15]}}, v[15:0]};
      W32:     r = {{(ValueW-32){v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/isw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module isw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/integer_set_with_width_upgrade.sv
// Top level: bounded integer multiset with a grow-only element width.
// Depends on isw_pkg and isw_ram.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  command   | op_i, value_i, value_type_i                | taken when start && !busy
//  result    | ok_o, full_res_o, element_count_o,         | valid while done_o is high,
//            | byte_size_o, width_code_o                  | for one cycle only
//
// Insert, refused insert, unknown op and type-refused delete/find: result in the cycle
// after the command. Find and delete scan the stored entries through the single RAM
// read port, one entry per cycle; a delete that hits then reads the last entry and
// writes it into the freed slot (states S_MOVE_RD and S_MOVE_WR).
// Reset empties the set and sets the width to 16 bits; no clearing pass is needed.
// busy is high while a scan or a move runs; the result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_set_with_width_upgrade
  import isw_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [63:0] value_i,
  input  wire logic [1:0]         value_type_i,
  output logic                    done_o,
  output logic                    ok_o,
  output logic                    full_res_o,
  output logic [6:0]              element_count_o,
  output logic [9:0]              byte_size_o,
  output logic [1:0]              width_code_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [ValueW-1:0] v_q;
  logic [CW-1:0]     count_q;
  width_e            width_q;
  logic [CW-1:0]     idx_q;
  logic              pend_q;
  logic [AW-1:0]     pend_idx_q;
  logic [AW-1:0]     pos_q;
  logic              done_q;
  logic              ok_q;
  logic              full_q;

  // Decoded command
  op_e               op_in;
  width_e            code_in;
  logic [ValueW-1:0] v_in;
  logic              accept;
  logic              room;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  // Scan control
  logic              issue;
  logic              hit;
  logic [CW-1:0]     last_idx;

  assign op_in   = op_e'(op_i);
  assign code_in = type_code(value_type_i);
  assign v_in    = sign_fit(ValueW'(value_i), code_in);
  assign accept  = start && (state_q == S_IDLE);
  assign room    = (count_q < CW'(CAPACITY));
  assign busy    = (state_q != S_IDLE);

  assign issue    = (idx_q < count_q);
  assign hit      = pend_q && (ram_rdata == v_q);
  assign last_idx = count_q - CW'(1);

  // RAM write: append on insert, move the last entry on a delete hit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = v_in;
    if (state_q == S_MOVE_WR) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q;
      ram_wdata = ram_rdata;
    end else if (accept && (op_in == OP_INSERT) && room) begin
      ram_we = 1'b1;
    end
  end

  // RAM read: scan index, or the last entry when moving
  assign ram_raddr = (state_q == S_MOVE_RD) ? last_idx[AW-1:0] : idx_q[AW-1:0];

  isw_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer, set state and registered result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_NONE;
      v_q        <= '0;
      count_q    <= '0;
      width_q    <= W16;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      pos_q      <= '0;
      done_q     <= 1'b0;
      ok_q       <= 1'b0;
      full_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= op_in;
            v_q    <= v_in;
            idx_q  <= '0;
            pend_q <= 1'b0;
            ok_q   <= 1'b0;
            full_q <= 1'b0;
            unique case (op_in)
              OP_INSERT: begin
                done_q <= 1'b1;
                if (room) begin
                  count_q <= count_q + CW'(1);
                  ok_q    <= 1'b1;
                  if (code_in > width_q) begin
                    width_q <= code_in;
                  end
                end else begin
                  full_q <= 1'b1;
                end
              end
              OP_DELETE: begin
                if (code_in == width_q) begin
                  state_q <= S_SCAN;
                end else begin
                  done_q <= 1'b1;
                end
              end
              OP_FIND: begin
                if (code_in <= width_q) begin
                  state_q <= S_SCAN;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one read issued and one compare per cycle
          pend_q     <= issue;
          pend_idx_q <= idx_q[AW-1:0];
          if (issue) begin
            idx_q <= idx_q + CW'(1);
          end
          if (hit) begin
            if (op_q == OP_FIND) begin
              ok_q    <= 1'b1;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              pos_q   <= pend_idx_q;
              state_q <= S_MOVE_RD;
            end
          end else if (!issue) begin
            // no match: a delete still reports the type match
            ok_q    <= (op_q == OP_DELETE);
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_MOVE_RD: begin
          state_q <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          count_q <= last_idx;
          ok_q    <= 1'b1;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result ports
  logic [9:0] count10;
  logic [2:0] shamt;

  assign count10         = 10'(count_q);
  assign shamt           = 3'(width_q) + 3'd1;
  assign done_o          = done_q;
  assign ok_o            = ok_q;
  assign full_res_o      = full_q;
  assign element_count_o = 7'(count_q);
  assign byte_size_o     = count10 << shamt;
  assign width_code_o    = width_q;

endmodule

`default_nettype wire

FILE: sv/isw_checker.sv
// Port-level checker for integer_set_with_width_upgrade, bound to the top level.
// Depends on isw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isw_checker
  import isw_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         op_i,
  input wire logic               done_o,
  input wire logic               ok_o,
  input wire logic               full_res_o,
  input wire logic [6:0]         element_count_o,
  input wire logic [1:0]         width_code_o
);

  // every accepted transaction either completes next cycle or holds busy
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("transaction neither completed nor started a scan");

  // a refused insert never reports success
  a_full_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full_res_o) |-> !ok_o)
    else $error("full and ok reported together");

  // only an insert can report a full table
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_e'(op_i) != OP_INSERT)) |=> !full_res_o)
    else $error("full reported for a non-insert");

  // the width never narrows
  a_width_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_code_o >= $past(width_code_o))
    else $error("element width shrank");

  // the count only moves because of a transaction
  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(start) && !$past(busy)) |-> $stable(element_count_o))
    else $error("count changed while idle");

endmodule

bind integer_set_with_width_upgrade isw_checker u_isw_checker (.*);

`default_nettype wire

FILE: bench/tb_integer_set_with_width_upgrade.sv
// Self-checking bench for the integer set with grow-only element width.
// Needs isw_pkg and integer_set_with_width_upgrade; predicts each result from
// its own copy of the set and checks every done_o strobe against it.
`timescale 1ns / 1ps

module tb_integer_set_with_width_upgrade;
  import isw_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DrainCycles = CAPACITY + 8;

  // Expected contents of one result transaction
  typedef struct packed {
    logic       ok;
    logic       full;
    logic [6:0] count;
    logic [9:0] bytes;
    width_e     width;
  } set_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic [1:0]         op_q = OP_NONE;
  logic signed [63:0] value_q = '0;
  logic [1:0]         value_type_q = 2'd0;
  logic               busy;
  logic               done_o;
  logic               ok_o;
  logic               full_res_o;
  logic [6:0]         element_count_o;
  logic [9:0]         byte_size_o;
  logic [1:0]         width_code_o;

  // Predicted set state
  logic [63:0]  held_entries [CAPACITY];
  int unsigned  held_count = 0;
  width_e       held_width = W16;

  set_result_t  pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  idle_pct = 0;

  integer_set_with_width_upgrade #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_q),
    .value_i        (value_q),
    .value_type_i   (value_type_q),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .full_res_o     (full_res_o),
    .element_count_o(element_count_o),
    .byte_size_o    (byte_size_o),
    .width_code_o   (width_code_o)
  );

  always #6 clk_i = ~clk_i;

  // Type code three counts as 64-bit
  function automatic width_e operand_width(logic [1:0] t);
    if (t == 2'd0) return W16;
    if (t == 2'd1) return W32;
    return W64;
  endfunction

  function automatic logic [63:0] extend_operand(logic [63:0] raw, width_e code);
    if (code == W16) return 64'(signed'(raw[15:0]));
    if (code == W32) return 64'(signed'(raw[31:0]));
    return raw;
  endfunction

  // First slot holding v, or held_count when absent
  function automatic int unsigned find_slot(logic [63:0] v);
    for (int unsigned i = 0; i < held_count; i++) begin
      if (held_entries[i] == v) return i;
    end
    return held_count;
  endfunction

  // Apply one command to the predicted set and return its result
  function automatic set_result_t predict_command(op_e op, logic [63:0] raw, logic [1:0] t);
    width_e      code;
    logic [63:0] v;
    int unsigned slot;
    int unsigned bytes;
    set_result_t r;
    code = operand_width(t);
    v = extend_operand(raw, code);
    r = '0;
    case (op)
      OP_INSERT: begin
        if (held_count >= CAPACITY) begin
          r.full = 1'b1;
        end else begin
          held_entries[held_count] = v;
          held_count++;
          if (code > held_width) held_width = code;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        // type must equal the width; a miss still reports ok
        if (code == held_width) begin
          r.ok = 1'b1;
          slot = find_slot(v);
          if (slot < held_count) begin
            held_entries[slot] = held_entries[held_count - 1];
            held_count--;
          end
        end
      end
      OP_FIND: begin
        if (code <= held_width && find_slot(v) < held_count) r.ok = 1'b1;
      end
      default: ;
    endcase
    bytes = held_count << (int'(held_width) + 1);
    r.count = 7'(held_count);
    r.bytes = 10'(bytes);
    r.width = held_width;
    return r;
  endfunction

  // Drive one command, wait until it is taken, then record its result
  task automatic send_command(op_e op, logic [63:0] v, logic [1:0] t);
    logic taken;
    int unsigned gap;
    start <= 1'b1;
    op_q <= op;
    value_q <= v;
    value_type_q <= t;
    do begin
      @(negedge clk_i);
      taken = (busy === 1'b0);
      @(posedge clk_i);
    end while (!taken);
    pending_results.insert(pending_results.size(), predict_command(op, v, t));
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 72) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Operand of type t: small, extreme, held or raw, with junk above the type
  function automatic logic [63:0] pick_value(logic [1:0] t, bit from_set);
    logic [63:0] v;
    logic [63:0] core;
    logic [63:0] top;
    int          s;
    width_e      code;
    code = operand_width(t);
    v = {$urandom, $urandom};
    core = {$urandom, $urandom};
    top = (code == W16) ? 64'h7FFF : (code == W32) ? 64'h7FFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
    if (from_set && held_count > 0) begin
      core = held_entries[$urandom_range(0, held_count - 1)];
    end else begin
      case ($urandom_range(0, 4))
        0: begin
          s = int'($urandom_range(0, 16)) - 8;
          core = 64'(s);
        end
        1: core = top;
        2: core = ~top;
        3: if (held_count > 0) core = held_entries[$urandom_range(0, held_count - 1)];
        default: ;
      endcase
    end
    if (code == W16) v[15:0] = core[15:0];
    else if (code == W32) v[31:0] = core[31:0];
    else v = core;
    return v;
  endfunction

  function automatic logic [1:0] insert_type(width_e max_ins);
    if (max_ins == W64) return 2'($urandom_range(0, 3));
    return 2'($urandom_range(0, int'(max_ins)));
  endfunction

  // Insert up to capacity, then a few refused inserts of any type
  task automatic fill_table(width_e max_ins);
    logic [1:0] t;
    while (held_count < CAPACITY) begin
      t = insert_type(max_ins);
      send_command(OP_INSERT, pick_value(t, $urandom_range(0, 3) == 0), t);
    end
    repeat (3) begin
      t = 2'($urandom_range(0, 3));
      send_command(OP_INSERT, pick_value(t, 1'b0), t);
    end
  endtask

  // Delete held values at the current width until few remain
  task automatic drain_table();
    logic [1:0] t;
    while (held_count > 4) begin
      t = 2'(held_width);
      send_command(OP_DELETE, pick_value(t, 1'b1), t);
    end
  endtask

  // Mixed traffic; inserts never go wider than max_ins
  task automatic run_traffic(width_e max_ins, int unsigned items);
    int unsigned kind;
    logic [1:0]  t;
    for (int unsigned n = 0; n < items; n++) begin
      idle_pct = (n < items / 3) ? 25 : (n < 2 * items / 3) ? 76 : 0;
      if (n == items / 5) fill_table(max_ins);
      if (n == 4 * items / 5) drain_table();
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        t = insert_type(max_ins);
        send_command(OP_INSERT, pick_value(t, 1'b0), t);
      end else if (kind < 60) begin
        t = 2'(held_width);
        send_command(OP_DELETE, pick_value(t, 1'b1), t);
      end else if (kind < 75) begin
        t = 2'($urandom_range(0, 3));
        send_command(OP_FIND, pick_value(t, 1'b1), t);
      end else if (kind < 93) begin
        t = 2'($urandom_range(0, 3));
        send_command(kind[0] ? OP_DELETE : OP_FIND, pick_value(t, 1'b0), t);
      end else begin
        send_command(OP_NONE, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  // Directed checks, all with the set at 16-bit width
  task automatic test_empty_set();
    send_command(OP_FIND, 64'd0, 2'd0);
    send_command(OP_DELETE, 64'd0, 2'd0);
  endtask

  task automatic test_insert_extremes();
    send_command(OP_INSERT, 64'hABCD_0000_1234_7FFF, 2'd0);
    send_command(OP_INSERT, 64'h0000_0000_0000_8000, 2'd0);
    send_command(OP_INSERT, 64'h0, 2'd0);
    send_command(OP_INSERT, '1, 2'd0);
    send_command(OP_INSERT, 64'h5555_5555_5555_0000, 2'd0);
  endtask

  // Promotion of narrow operands; wider ones never hit
  task automatic test_find_rules();
    send_command(OP_FIND, 64'hFFFF_FFFF_FFFF_8000, 2'd0);
    send_command(OP_FIND, 64'h0000_0000_0000_8000, 2'd1);
    send_command(OP_FIND, 64'h0000_0000_0000_8000, 2'd3);
    send_command(OP_FIND, 64'h7FFF_FFFF_FFFF_FFFF, 2'd2);
    send_command(OP_FIND, 64'h8000_0000_0000_0000, 2'd2);
  endtask

  // Type mismatch, miss, hit and duplicate removal
  task automatic test_delete_rules();
    send_command(OP_DELETE, '1, 2'd1);
    send_command(OP_DELETE, 64'h7FFF, 2'd3);
    send_command(OP_DELETE, 64'd5, 2'd0);
    send_command(OP_DELETE, 64'hFFFF_FFFF_FFFF_7FFF, 2'd0);
    send_command(OP_INSERT, 64'hAAAA_AAAA_AAAA_0000, 2'd0);
    send_command(OP_DELETE, 64'd0, 2'd0);
    send_command(OP_FIND, 64'd0, 2'd0);
  endtask

  task automatic test_unknown_op();
    send_command(OP_NONE, '1, 2'd3);
    send_command(OP_NONE, 64'd0, 2'd0);
  endtask

  task automatic test_narrow_traffic();
    run_traffic(W16, 140);
  endtask

  task automatic test_upgrade_to_32();
    run_traffic(W32, 140);
  endtask

  task automatic test_upgrade_to_64();
    run_traffic(W64, 140);
  endtask

  // Compare every result transaction with the oldest prediction
  always @(negedge clk_i) begin
    set_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: count %0d width %0d", element_count_o, width_code_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          mismatches++;
        end
        if (full_res_o !== want.full) begin
          $error("full_res: expected %0b, got %0b", want.full, full_res_o);
          mismatches++;
        end
        if (element_count_o !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count, element_count_o);
          mismatches++;
        end
        if (byte_size_o !== want.bytes) begin
          $error("byte_size: expected %0d, got %0d", want.bytes, byte_size_o);
          mismatches++;
        end
        if (width_code_o !== want.width) begin
          $error("width_code: expected %0d, got %0d", want.width, width_code_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 25;
    test_empty_set();
    test_insert_extremes();
    test_find_rules();
    test_delete_rules();
    test_unknown_op();
    test_narrow_traffic();
    test_upgrade_to_32();
    test_upgrade_to_64();
    start <= 1'b0;
    // let the last scan finish, then a margin for stray strobes
    waited = 0;
    while (pending_results.size() != 0 && waited < 4 * DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("integer_set_with_width_upgrade regression: pass");
    end else begin
      $display("integer_set_with_width_upgrade regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10ms;
    $display("integer_set_with_width_upgrade regression: fail");
    $finish;
  end

endmodule

FILE: files.f
sv/isw_pkg.sv
sv/isw_ram.sv
sv/integer_set_with_width_upgrade.sv
sv/isw_checker.sv
bench/tb_integer_set_with_width_upgrade.sv
